// ===== rtl/core/exp_golomb_bit_writer_assert.svh =====
// Assertion macros for the Exp-Golomb bit writer checker.
// Included by the checker file; needs nothing else.
`ifndef EXP_GOLOMB_BIT_WRITER_ASSERT_SVH
`define EXP_GOLOMB_BIT_WRITER_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define EGW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define EGW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/egw_pkg.sv =====
// Shared types and constants for the Exp-Golomb bit writer.
// No dependencies; imported by egw_coder and the top level.
`default_nettype none

package egw_pkg;

    localparam int C_MAX_FIELD_BITS = 32;
    localparam int C_CODE_BITS      = 65;
    localparam int C_BUF_BITS       = 72;

    typedef enum logic [1:0] {
        K_FIXED = 2'd0,
        K_UE    = 2'd1,
        K_SE    = 2'd2,
        K_STOP  = 2'd3
    } t_kind;

    // One element as a left-aligned bit string
    typedef struct packed {
        logic [C_CODE_BITS-1:0] word;
        logic [6:0]             len;
        logic                   stop;
    } t_code;

    // Leading zeros of a 33-bit non-zero code
    function automatic logic [5:0] f_clz33(input logic [32:0] x);
        logic [5:0] lz;
        lz = 6'd33;
        for (int i = 0; i < 33; i++) begin
            if (x[i]) begin
                lz = 6'(32 - i);
            end
        end
        return lz;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/egw_coder.sv =====
// Two-stage element coder: forms the code number, then the left-aligned bit string.
// Depends on egw_pkg.
`default_nettype none

module egw_coder import egw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_bit_count,
    output logic        o_valid,
    input  logic        i_ready,
    output t_code       o_code
);

    logic        r_s1_valid;
    t_kind       r_s1_kind;
    logic [32:0] r_s1_data;
    logic [5:0]  r_s1_cnt;
    logic        r_s2_valid;
    t_code       r_s2_code;

    t_kind       n_s1_kind;
    logic [32:0] n_s1_data;
    logic [5:0]  n_s1_cnt;
    t_code       n_s2_code;
    logic [5:0]  s2_lz;
    logic [6:0]  s2_shamt;
    logic        s1_ready;
    logic        s2_ready;

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    // Stage 1: saturate the field width and map a ue(v) or se(v) value to its code number plus one
    always_comb begin
        n_s1_kind = t_kind'(i_kind);
        n_s1_cnt  = (i_bit_count > 6'(C_MAX_FIELD_BITS)) ? 6'(C_MAX_FIELD_BITS) : i_bit_count;
        n_s1_data = {1'b0, i_value};
        case (n_s1_kind)
            K_UE: begin
                n_s1_data = {1'b0, i_value} + 33'd1;
            end
            K_SE: begin
                if (i_value[31]) begin
                    n_s1_data = {(~i_value) + 32'd1, 1'b1};
                end else if (i_value == 32'd0) begin
                    n_s1_data = 33'd1;
                end else begin
                    n_s1_data = {i_value, 1'b0};
                end
            end
            default: ;
        endcase
    end

    // Stage 2: left-align the bits, leading zeros included
    always_comb begin
        s2_lz          = f_clz33(r_s1_data);
        s2_shamt       = {s2_lz, 1'b0};
        n_s2_code.word = {1'b1, 64'd0};
        n_s2_code.len  = 7'd0;
        n_s2_code.stop = 1'b1;
        case (r_s1_kind)
            K_FIXED: begin
                n_s2_code.word = {r_s1_data[31:0], 33'd0} << (6'd32 - r_s1_cnt);
                n_s2_code.len  = {1'b0, r_s1_cnt};
                n_s2_code.stop = 1'b0;
            end
            K_UE, K_SE: begin
                n_s2_code.word = {32'd0, r_s1_data} << s2_shamt;
                n_s2_code.len  = 7'd65 - s2_shamt;
                n_s2_code.stop = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_kind <= n_s1_kind;
            r_s1_data <= n_s1_data;
            r_s1_cnt  <= n_s1_cnt;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_code <= n_s2_code;
        end
    end

    assign o_ready = s1_ready;
    assign o_valid = r_s2_valid;
    assign o_code  = r_s2_code;

endmodule

`default_nettype wire

// ===== rtl/core/exp_golomb_bit_writer.sv =====
// H.264 syntax-element bit writer: coder pipeline, bit buffer and byte output register.
// Depends on egw_pkg and egw_coder.
//
// Input channel (i_in_valid / o_in_ready) takes one syntax element per transaction:
// i_kind selects fixed bits, ue(v), se(v) or the stop bit with byte-align padding.
// Output channel (o_out_valid / i_out_ready) gives one completed byte per transaction,
// first written bit in the msb; o_last_byte marks the final byte an element completed.
// An element that completes no byte gives no output transaction.
// The first byte of an element passes the two coder stages, the bit buffer and the
// output register on its way from the input transaction to the output.
// Throughput: one element per cycle while each element completes at most one byte and the
// receiver takes bytes. The buffer releases one byte per cycle while the receiver takes them,
// so a longer element holds it until its bytes are out; the coder stages take elements meanwhile.
// When the receiver stalls, the byte holds in the output register, the buffer and
// the coder stages fill, then o_in_ready drops.
// Reset empties every stage and clears the partial byte and fill count.
`default_nettype none

module exp_golomb_bit_writer import egw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_bit_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    logic                  code_valid;
    logic                  code_ready;
    t_code                 code;

    logic [C_BUF_BITS-1:0] r_buf;
    logic [6:0]            r_nbits;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;

    logic [C_BUF_BITS-1:0] n_buf;
    logic [6:0]            n_nbits;
    logic                  pop;
    logic                  load;
    logic [6:0]            after_nbits;
    logic [C_BUF_BITS-1:0] shifted;
    logic [2:0]            carry;
    logic [6:0]            word_len;

    egw_coder u_coder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .o_valid     (code_valid),
        .i_ready     (code_ready),
        .o_code      (code)
    );

    // Release a full byte whenever the output register is free
    assign pop         = (r_nbits >= 7'd8) && (!r_out_valid || i_out_ready);
    assign after_nbits = pop ? (r_nbits - 7'd8) : r_nbits;
    assign shifted     = pop ? (r_buf << 8) : r_buf;
    assign code_ready  = (after_nbits < 7'd8);
    assign load        = code_valid && code_ready;
    assign carry       = after_nbits[2:0];
    assign word_len    = code.stop ? (7'd8 - {4'd0, carry}) : code.len;

    // Append the next element behind the partial byte left over
    always_comb begin
        n_buf   = shifted;
        n_nbits = after_nbits;
        if (load) begin
            n_buf   = shifted | ({code.word, 7'd0} >> carry);
            n_nbits = after_nbits + word_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= '0;
            r_nbits     <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_buf   <= n_buf;
            r_nbits <= n_nbits;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_byte <= r_buf[C_BUF_BITS-1 -: 8];
            r_out_last <= (r_nbits < 7'd16);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/egw_checker.sv =====
// Port-level checker for the Exp-Golomb bit writer, bound to the top level.
// Depends on exp_golomb_bit_writer_assert.svh.
`default_nettype none

`include "exp_golomb_bit_writer_assert.svh"

module egw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_last_byte
);

    logic       out_stall;
    logic [8:0] out_word;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_word  = {o_out_byte, o_last_byte};

    // A stalled output transaction stays offered
    `EGW_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> o_out_valid, "output dropped")

    // Hold the byte and its flag while the receiver stalls
    `EGW_ASSERT(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable(out_word), "payload changed")

    // Reset leaves no byte pending on the output
    `EGW_ASSERT_ALWAYS(a_rst_out_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // Reset empties the coder, so the input side is ready at once
    `EGW_ASSERT_ALWAYS(a_rst_in_ready, i_clk, !i_rst_n |=> o_in_ready, "input not ready after reset")

endmodule

bind exp_golomb_bit_writer egw_checker u_egw_checker (.*);

`default_nettype wire
